// ===== hw/rtl/cps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk pool suballocator package
// Shared payload types and register indexes.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 40;

  localparam logic [CfgIdxW-1:0] CFG_DEFAULT_CHUNK = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MEMORY_LIMIT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SCRATCH_MODE  = 2'd2;

  localparam logic KIND_ALLOC  = 1'b0;
  localparam logic KIND_SUBMIT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] request_bytes;
    logic [4:0]  align_log2;
    logic [31:0] tag_instance;
    logic        tag_submitted;
    logic [31:0] new_instance;
    logic        new_submitted;
    logic [31:0] completed_instance;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  chunk_index;
    logic [39:0] region_offset;
    logic [39:0] region_address;
    logic        barrier_needed;
  } rsp_t;

  // Per-slot tag, kept in flip-flops so a scan can read and rewrite it.
  typedef struct packed {
    logic [31:0] inst;
    logic        sub;
  } tag_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cps_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module cps_ram #(
  parameter int unsigned Width = 40,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/chunk_pool_suballocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk pool suballocator
// Linear bump allocator over a pool of chunks with completion-based recycling.
// ----------------------------------------------------------------------------
//  Channel | Handshake                   | Payload
//  --------+-----------------------------+------------------------
//  request | req_valid_i / req_ready_o   | req_i  (cps_pkg::req_t)
//  result  | rsp_valid_o / rsp_ready_i   | rsp_o  (cps_pkg::rsp_t)
//  config  | cfg_we_i                    | cfg_idx_i, cfg_data_i
//
// One transfer is worked on at a time by a small sequencer. A refill walks
// the pool one entry at a time, with a registered RAM read of the chunk size
// for each entry, and walks it again when the scratch fallback runs. Reset
// clears the sequencer state, configuration and pool counters; slot RAM
// contents are undefined until a chunk is created. A stalled result holds
// the block in its output state; the next request is taken once the result
// is taken.
module chunk_pool_suballocator #(
  parameter int unsigned POOL_SLOTS       = 16,
  parameter int unsigned CHUNK_ALIGN_LOG2 = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [cps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [cps_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                    req_valid_i,
  output logic                         req_ready_o,
  input  wire cps_pkg::req_t           req_i,
  output logic                         rsp_valid_o,
  input  wire logic                    rsp_ready_i,
  output cps_pkg::rsp_t                rsp_o
);
  import cps_pkg::*;

  localparam int unsigned SlotW = $clog2(POOL_SLOTS);
  localparam int unsigned CntW  = $clog2(POOL_SLOTS + 1);
  localparam logic [39:0] M40   = {40{1'b1}};
  localparam logic [39:0] CaMask = (40'd1 << CHUNK_ALIGN_LOG2) - 40'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_FAST, S_FAST2, S_SUBMIT, S_FREE_RD, S_FREE_CHK, S_CREATE,
    S_SCR_RD, S_SCR_CHK, S_SCR_DONE, S_FIN, S_BASE_RD, S_BASE_WAIT, S_OUT
  } state_e;

  state_e state_q;
  req_t   r_q;
  logic [31:0] def_q;
  logic [39:0] lim_q;
  logic        scr_q;

  tag_t            tag_q   [POOL_SLOTS];
  logic [SlotW-1:0] order_q [POOL_SLOTS];
  logic [CntW-1:0] plen_q, created_q, i_q;
  logic            cur_v_q, have_ret_q, found_q;
  logic [SlotW-1:0] cur_q, ret_q, best_q;
  logic [CntW-1:0] bpos_q;
  logic [39:0]     wpos_q, alloc_q, want_q, aligned_q, bbytes_q;
  logic            barrier_q;
  rsp_t            rsp_q;

  // Chunk size and base RAMs, one shared read address.
  logic             ram_we;
  logic [SlotW-1:0] ram_waddr, ram_raddr;
  logic [39:0]      bytes_rd, base_rd, bytes_wd, base_wd;

  cps_ram #(.Width(40), .Depth(POOL_SLOTS)) u_bytes (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(bytes_wd),
    .raddr_i(ram_raddr), .rdata_o(bytes_rd));
  cps_ram #(.Width(40), .Depth(POOL_SLOTS)) u_base (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(base_wd),
    .raddr_i(ram_raddr), .rdata_o(base_rd));

  logic [SlotW-1:0] scan_slot;
  assign scan_slot = order_q[i_q[SlotW-1:0]];

  // Address: current slot except while walking the pool.
  always_comb begin
    ram_raddr = cur_q;
    if (state_q == S_FREE_RD || state_q == S_SCR_RD) begin
      ram_raddr = scan_slot;
    end
  end

  // Creation writes both RAMs in the same cycle.
  logic [39:0] want_sz, want_rnd;
  logic [40:0] lim_sum;
  always_comb begin
    want_sz  = (r_q.request_bytes > def_q) ? {8'd0, r_q.request_bytes} : {8'd0, def_q};
    want_rnd = (want_sz + CaMask) & ~CaMask;
    lim_sum  = {1'b0, alloc_q} + {1'b0, want_q};
  end
  assign ram_we    = (state_q == S_CREATE) && !((lim_q != '0) && (lim_sum > {1'b0, lim_q}))
                     && (created_q < CntW'(POOL_SLOTS));
  assign ram_waddr = created_q[SlotW-1:0];
  assign bytes_wd  = want_q;
  assign base_wd   = alloc_q;

  // Fast path arithmetic.
  logic [39:0] amask, aligned_c;
  logic [40:0] end_c;
  always_comb begin
    amask     = (40'd1 << r_q.align_log2) - 40'd1;
    aligned_c = (wpos_q + amask) & ~amask;
    end_c     = {1'b0, aligned_q} + {8'd0, r_q.request_bytes};
  end

  tag_t cur_tag;
  assign cur_tag = tag_q[scan_slot];

  logic better;
  always_comb begin
    better = (cur_tag.sub && !tag_q[best_q].sub) ||
             (cur_tag.sub == tag_q[best_q].sub && cur_tag.inst < tag_q[best_q].inst) ||
             (cur_tag.sub == tag_q[best_q].sub && cur_tag.inst == tag_q[best_q].inst &&
              bytes_rd > bbytes_q);
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_OUT);
  assign rsp_o       = rsp_q;

  // Pool order with one entry taken out; the entries after it shift down by one.
  logic [CntW-1:0]  rm_pos;
  logic [SlotW-1:0] order_rm [POOL_SLOTS];
  always_comb begin
    rm_pos   = (state_q == S_SCR_DONE) ? bpos_q : i_q;
    order_rm = order_q;
    for (int k = 0; k < POOL_SLOTS - 1; k++) begin
      if (CntW'(k) >= rm_pos) order_rm[k] = order_q[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      def_q      <= 32'd4194304;
      lim_q      <= '0;
      scr_q      <= 1'b0;
      plen_q     <= '0;
      created_q  <= '0;
      cur_v_q    <= 1'b0;
      cur_q      <= '0;
      wpos_q     <= '0;
      alloc_q    <= '0;
      i_q        <= '0;
      have_ret_q <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEFAULT_CHUNK: def_q <= cfg_data_i[31:0];
          CFG_MEMORY_LIMIT:  lim_q <= cfg_data_i;
          CFG_SCRATCH_MODE:  scr_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            r_q        <= req_i;
            i_q        <= '0;
            have_ret_q <= 1'b0;
            found_q    <= 1'b0;
            barrier_q  <= 1'b0;
            if (req_i.kind == KIND_SUBMIT) begin
              if (cur_v_q) begin
                if (plen_q < CntW'(POOL_SLOTS)) begin
                  order_q[plen_q[SlotW-1:0]] <= cur_q;
                  plen_q <= plen_q + 1'b1;
                end
                cur_v_q <= 1'b0;
              end
              state_q <= S_SUBMIT;
            end else if (cur_v_q) begin
              state_q <= S_FAST;
            end else begin
              state_q <= S_FREE_RD;
            end
          end
        end
        S_SUBMIT: begin
          if (i_q >= plen_q) begin
            rsp_q   <= '{ok: 1'b1, default: '0};
            state_q <= S_OUT;
          end else begin
            if (cur_tag.inst == r_q.tag_instance && cur_tag.sub == r_q.tag_submitted) begin
              tag_q[scan_slot] <= '{inst: r_q.new_instance, sub: r_q.new_submitted};
            end
            i_q <= i_q + 1'b1;
          end
        end
        S_FAST: begin
          aligned_q <= aligned_c;
          state_q   <= S_FAST2;
        end
        S_FAST2: begin
          // bytes_rd and base_rd hold the current slot.
          if (end_c <= {1'b0, bytes_rd}) begin
            wpos_q  <= end_c[39:0];
            rsp_q   <= '{ok: 1'b1, chunk_index: 4'(cur_q), region_offset: aligned_q,
                         region_address: base_rd + aligned_q, barrier_needed: 1'b0};
            state_q <= S_OUT;
          end else begin
            have_ret_q <= 1'b1;
            ret_q      <= cur_q;
            cur_v_q    <= 1'b0;
            state_q    <= S_FREE_RD;
          end
        end
        S_FREE_RD: begin
          want_q <= want_rnd;
          if (i_q >= plen_q) begin
            if (have_ret_q && plen_q < CntW'(POOL_SLOTS)) begin
              order_q[plen_q[SlotW-1:0]] <= ret_q;
              plen_q <= plen_q + 1'b1;
            end
            state_q <= S_CREATE;
          end else begin
            state_q <= S_FREE_CHK;
          end
        end
        S_FREE_CHK: begin
          if (cur_tag.sub && cur_tag.inst <= r_q.completed_instance) begin
            tag_q[scan_slot] <= '0;
          end
          if (((cur_tag.sub && cur_tag.inst <= r_q.completed_instance) ||
               (cur_tag.inst == '0 && !cur_tag.sub)) &&
              bytes_rd >= {8'd0, r_q.request_bytes}) begin
            cur_q   <= scan_slot;
            cur_v_q <= 1'b1;
            // The retired chunk takes the last place of the shortened pool.
            for (int k = 0; k < POOL_SLOTS; k++) begin
              order_q[k] <= (have_ret_q && CntW'(k) == plen_q - 1'b1) ? ret_q : order_rm[k];
            end
            if (!have_ret_q) begin
              plen_q <= plen_q - 1'b1;
            end
            state_q <= S_FIN;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_FREE_RD;
          end
        end
        S_CREATE: begin
          i_q <= '0;
          if ((lim_q != '0) && (lim_sum > {1'b0, lim_q})) begin
            if (!scr_q) begin
              rsp_q   <= '0;
              state_q <= S_OUT;
            end else begin
              state_q <= S_SCR_RD;
            end
          end else if (created_q >= CntW'(POOL_SLOTS)) begin
            rsp_q   <= '0;
            state_q <= S_OUT;
          end else begin
            cur_q     <= created_q[SlotW-1:0];
            cur_v_q   <= 1'b1;
            created_q <= created_q + 1'b1;
            alloc_q   <= lim_sum[40] ? M40 : lim_sum[39:0];
            state_q   <= S_FIN;
          end
        end
        S_SCR_RD: begin
          state_q <= (i_q >= plen_q) ? S_SCR_DONE : S_SCR_CHK;
        end
        S_SCR_CHK: begin
          if (bytes_rd >= want_q && (!found_q || better)) begin
            found_q  <= 1'b1;
            best_q   <= scan_slot;
            bpos_q   <= i_q;
            bbytes_q <= bytes_rd;
          end
          i_q     <= i_q + 1'b1;
          state_q <= S_SCR_RD;
        end
        S_SCR_DONE: begin
          if (!found_q) begin
            rsp_q   <= '0;
            state_q <= S_OUT;
          end else begin
            order_q   <= order_rm;
            plen_q    <= plen_q - 1'b1;
            cur_q     <= best_q;
            cur_v_q   <= 1'b1;
            barrier_q <= 1'b1;
            state_q   <= S_FIN;
          end
        end
        S_FIN: begin
          tag_q[cur_q] <= '{inst: r_q.tag_instance, sub: r_q.tag_submitted};
          wpos_q       <= {8'd0, r_q.request_bytes};
          state_q      <= S_BASE_RD;
        end
        S_BASE_RD: begin
          state_q <= S_BASE_WAIT;
        end
        S_BASE_WAIT: begin
          rsp_q   <= '{ok: 1'b1, chunk_index: 4'(cur_q), region_offset: '0,
                       region_address: base_rd, barrier_needed: barrier_q};
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (rsp_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The pool never holds more entries than there are slots created.
  a_pool_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q <= created_q) else $error("pool longer than created slots");
  // No request is accepted while a result is pending.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o) else $error("ready while result pending");
  // A failed allocation reports a zero address and no barrier.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.ok) |-> (rsp_o.region_address == '0 && !rsp_o.barrier_needed))
    else $error("failure with nonzero fields");
endmodule
`default_nettype wire
